// ----- rtl/tlj_pkg.sv -----
package tlj_pkg;

  localparam int unsigned LINE_CAP   = 32;
  localparam int unsigned WORD_SLOTS = (LINE_CAP + 1) / 2;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [5:0] WIDTH_RESET = 6'd32;

  typedef enum logic [1:0] {
    ACT_CHAR = 2'd0,
    ACT_SEP  = 2'd1,
    ACT_EOT  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

endpackage

// ----- rtl/text_line_full_justifier.sv -----
// Greedy full justification of a character stream.
// The input channel carries one action per item: a word character, a word
// separator or an end of text. Characters collect into a pending word; a
// separator or end of text commits the word to the current line, flushing
// the line first, fully justified, when the word does not fit behind one
// space or when sixteen words are already on the line. End of text also
// sets the last line flush left and pads it. Every line is exactly W
// characters, W being cfg_data saturated to 1..32 (32 after reset).
// A commit copies the pending word from its memory into the line memory
// character by character. A justified line of more than one word first
// runs the gap divider; the single read port of the line memory sets the
// pace of the output. No input is taken while a commit or a line is in
// progress. A stalled receiver simply holds the output register and the
// sequencer waits on it; nothing is lost. Reset empties the line and the
// pending word and sets the width back to 32; the memories are not
// cleared. The width may be written only while the block is idle.
module text_line_full_justifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // action[1:0], ch[9:2], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,   // line_width
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_char[7:0]
  output logic        out_tlast,  // line_end
  output logic [1:0]  out_tuser   // last_of_run[0], overflow[1]
);

  typedef enum logic [3:0] {
    S_IDLE, S_CM, S_DIV, S_EW, S_GAP, S_WRD, S_WRD2, S_PAD, S_CP, S_CP2
  } state_t;

  state_t state_r;

  logic [5:0] width_r;
  logic [5:0] pl_r;
  logic       tf_r;
  logic [4:0] wc_r;
  logic [5:0] used_r;
  logic [5:0] letters_r;
  logic       lflag_r;
  logic       eot_r;
  logic       flush_r;
  logic       just_r;
  logic [5:0] cm_len_r;
  logic       cm_tr_r;
  logic [5:0] k_r;
  logic [5:0] pos_r;
  logic [4:0] wi_r;
  logic [5:0] src_r;
  logic [5:0] rem_r;
  logic [5:0] gap_r;
  logic [4:0] dq_r;
  logic [3:0] drem_r;
  logic [2:0] dcnt_r;

  logic       ov_r;
  logic [7:0] och_r;
  logic       olast_r;
  logic       orun_r;
  logic       oflow_r;

  logic [7:0] lt_mem [tlj_pkg::LINE_CAP];
  logic [7:0] pw_mem [tlj_pkg::LINE_CAP];
  logic [5:0] wlen_r [tlj_pkg::WORD_SLOTS];
  logic [7:0] lt_rd_r;
  logic [7:0] pw_rd_r;

  logic [5:0] weff;
  logic       in_acc;
  logic [1:0] in_act;
  logic [7:0] in_ch;
  logic       can;
  logic       pos_last;
  logic [5:0] spare;
  logic [3:0] gaps;
  logic [5:0] cm_len;
  logic       cm_tr;
  logic       cm_flush;
  logic [6:0] lt_waddr;
  logic       lt_we;
  logic       pw_we;
  logic [4:0] trial;
  logic [4:0] wi_m1;
  logic [5:0] gap_sz;
  logic       emit;
  logic [7:0] emit_ch;

  always_comb begin
    if (width_r == 6'd0) begin
      weff = 6'd1;
    end else if (width_r > 6'(tlj_pkg::LINE_CAP)) begin
      weff = 6'(tlj_pkg::LINE_CAP);
    end else begin
      weff = width_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign in_act    = in_tdata[1:0];
  assign in_ch     = in_tdata[9:2];
  assign can       = !ov_r || out_tready;
  assign pos_last  = (pos_r == weff - 6'd1);
  assign spare     = (weff > used_r) ? weff - used_r : 6'd0;
  assign gaps      = 4'(wc_r - 5'd1);
  assign cm_tr     = tf_r || (pl_r > weff);
  assign cm_len    = (pl_r > weff) ? weff : pl_r;
  assign cm_flush  = (wc_r != 5'd0) &&
                     (({1'b0, used_r} + 7'd1 + {1'b0, cm_len} > {1'b0, weff}) ||
                      (wc_r >= 5'(tlj_pkg::WORD_SLOTS)));
  assign lt_waddr  = {1'b0, letters_r} + {1'b0, k_r};
  assign lt_we     = (state_r == S_CP2) && (lt_waddr < 7'(tlj_pkg::LINE_CAP));
  assign pw_we     = in_acc && (in_act == tlj_pkg::ACT_CHAR) && (pl_r < weff);
  assign trial     = {drem_r, dq_r[4]};
  assign wi_m1     = wi_r - 5'd1;
  assign gap_sz    = 6'd1 + (just_r ? ({1'b0, dq_r} +
                     6'((wi_m1 < {1'b0, drem_r}) ? 1 : 0)) : 6'd0);

  always_comb begin
    emit    = 1'b0;
    emit_ch = tlj_pkg::SPACE_CHAR;
    unique case (state_r)
      S_GAP:   emit = can && (gap_r != 6'd0);
      S_PAD:   emit = can;
      S_WRD2: begin
        emit    = can;
        emit_ch = (src_r < 6'(tlj_pkg::LINE_CAP)) ? lt_rd_r : tlj_pkg::SPACE_CHAR;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lt_we) begin
      lt_mem[lt_waddr[4:0]] <= pw_rd_r;
    end
    lt_rd_r <= lt_mem[src_r[4:0]];
    if (pw_we) begin
      pw_mem[pl_r[4:0]] <= in_ch;
    end
    pw_rd_r <= pw_mem[k_r[4:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      width_r   <= tlj_pkg::WIDTH_RESET;
      pl_r      <= 6'd0;
      tf_r      <= 1'b0;
      wc_r      <= 5'd0;
      used_r    <= 6'd0;
      letters_r <= 6'd0;
      lflag_r   <= 1'b0;
      eot_r     <= 1'b0;
      flush_r   <= 1'b0;
      just_r    <= 1'b0;
      k_r       <= 6'd0;
      pos_r     <= 6'd0;
      wi_r      <= 5'd0;
      src_r     <= 6'd0;
      dcnt_r    <= 3'd0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_r <= cfg_data;
      end
      if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (emit) begin
        ov_r    <= 1'b1;
        och_r   <= emit_ch;
        olast_r <= pos_last;
        orun_r  <= pos_last && !(flush_r && eot_r);
        oflow_r <= lflag_r;
        pos_r   <= pos_r + 6'd1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            eot_r <= (in_act == tlj_pkg::ACT_EOT);
            if (in_act == tlj_pkg::ACT_CHAR) begin
              if (pl_r < weff) begin
                pl_r <= pl_r + 6'd1;
              end else begin
                tf_r <= 1'b1;
              end
            end else if (in_act == tlj_pkg::ACT_SEP || in_act == tlj_pkg::ACT_EOT) begin
              if (pl_r != 6'd0) begin
                state_r <= S_CM;
              end else if (in_act == tlj_pkg::ACT_EOT && wc_r != 5'd0) begin
                flush_r <= 1'b0;
                just_r  <= 1'b0;
                dq_r    <= 5'd0;
                drem_r  <= 4'd0;
                state_r <= S_EW;
              end
            end
          end
        end
        S_CM: begin
          cm_len_r <= cm_len;
          cm_tr_r  <= cm_tr;
          k_r      <= 6'd0;
          if (cm_flush) begin
            flush_r <= 1'b1;
            just_r  <= 1'b1;
            if (wc_r > 5'd1) begin
              dq_r    <= spare[4:0];
              drem_r  <= 4'd0;
              dcnt_r  <= 3'd0;
              state_r <= S_DIV;
            end else begin
              dq_r    <= 5'd0;
              drem_r  <= 4'd0;
              state_r <= S_EW;
            end
          end else begin
            state_r <= S_CP;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, gaps}) begin
            drem_r <= 4'(trial - {1'b0, gaps});
            dq_r   <= {dq_r[3:0], 1'b1};
          end else begin
            drem_r <= trial[3:0];
            dq_r   <= {dq_r[3:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 3'd1;
          if (dcnt_r == 3'd4) begin
            state_r <= S_EW;
          end
        end
        S_EW: begin
          if (wi_r >= wc_r) begin
            state_r <= S_PAD;
          end else begin
            rem_r <= wlen_r[wi_r[3:0]];
            wi_r  <= wi_r + 5'd1;
            if (wi_r != 5'd0) begin
              gap_r   <= gap_sz;
              state_r <= S_GAP;
            end else begin
              state_r <= S_WRD;
            end
          end
        end
        S_GAP: begin
          if (gap_r == 6'd0) begin
            state_r <= S_WRD;
          end else if (emit) begin
            gap_r <= gap_r - 6'd1;
          end
        end
        S_WRD: begin
          state_r <= (rem_r == 6'd0) ? S_EW : S_WRD2;
        end
        S_WRD2: begin
          if (emit) begin
            src_r   <= src_r + 6'd1;
            rem_r   <= rem_r - 6'd1;
            state_r <= S_WRD;
          end
        end
        S_PAD: begin
        end
        S_CP: begin
          if (k_r == cm_len_r) begin
            wlen_r[wc_r[3:0]] <= cm_len_r;
            used_r    <= (wc_r == 5'd0) ? cm_len_r : used_r + 6'd1 + cm_len_r;
            wc_r      <= wc_r + 5'd1;
            letters_r <= letters_r + cm_len_r;
            if (cm_tr_r) begin
              lflag_r <= 1'b1;
            end
            pl_r <= 6'd0;
            tf_r <= 1'b0;
            if (eot_r) begin
              flush_r <= 1'b0;
              just_r  <= 1'b0;
              dq_r    <= 5'd0;
              drem_r  <= 4'd0;
              state_r <= S_EW;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_CP2;
          end
        end
        S_CP2: begin
          k_r     <= k_r + 6'd1;
          state_r <= S_CP;
        end
        default: state_r <= S_IDLE;
      endcase

      if (emit && pos_last) begin
        wc_r      <= 5'd0;
        used_r    <= 6'd0;
        letters_r <= 6'd0;
        lflag_r   <= 1'b0;
        pos_r     <= 6'd0;
        wi_r      <= 5'd0;
        src_r     <= 6'd0;
        flush_r   <= 1'b0;
        state_r   <= flush_r ? S_CP : S_IDLE;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = och_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {oflow_r, orun_r};

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= 5'(tlj_pkg::WORD_SLOTS))
    else $error("word count beyond slot count");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < weff)
    else $error("line position reached width");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("end of run not on a line end");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pl_r <= 6'(tlj_pkg::LINE_CAP))
    else $error("pending word too long");

endmodule
